// ----- src/mesh_flood_duplicate_filter_unit_assert.svh -----
// Assertion macros for the mesh flood duplicate filter
`ifndef MESH_FLOOD_DUPLICATE_FILTER_UNIT_ASSERT_SVH
`define MESH_FLOOD_DUPLICATE_FILTER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
`define MFDF_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);
`define MFDF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define MFDF_ASSERT_NOW(lbl, ante, cons, msg)
`define MFDF_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ----- src/mfdf_pkg.sv -----
// Package of types and constants for the mesh flood duplicate filter
package mfdf_pkg;

    localparam int ID_W             = 8;
    localparam int SEQ_W            = 8;
    localparam int HOP_W            = 8;
    localparam int SOURCE_COUNT_DEF = 256;
    localparam int PADDR_W          = 4;
    localparam int PDATA_W          = 32;
    localparam int S_TDATA_W        = 32;
    localparam int M_TDATA_W        = 16;

    localparam logic [ID_W-1:0]  BROADCAST_ADDR = 8'd255;
    localparam logic [SEQ_W-1:0] SEQ_RESET      = 8'd255;

    localparam logic [ID_W-1:0]  OWN_ADDRESS_RST    = 8'd0;
    localparam logic [SEQ_W-1:0] WRAP_HIGH_MARK_RST = 8'd200;
    localparam logic [SEQ_W-1:0] WRAP_LOW_MARK_RST  = 8'd50;

    localparam logic [1:0] REG_OWN_ADDRESS    = 2'd0;
    localparam logic [1:0] REG_WRAP_HIGH_MARK = 2'd1;
    localparam logic [1:0] REG_WRAP_LOW_MARK  = 2'd2;

    typedef struct packed {
        logic [ID_W-1:0]  dest_id;
        logic [ID_W-1:0]  source_id;
        logic [SEQ_W-1:0] sequence_number;
        logic [HOP_W-1:0] hop_count;
    } header_t;

    typedef struct packed {
        logic             duplicate;
        logic [HOP_W-1:0] forward_hops;
        logic             forward;
        logic             deliver;
    } result_t;

endpackage

// ----- src/mfdf_ram.sv -----
// Generic single-write, single-read RAM with registered read data
module mfdf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                                     aclk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic                                     re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- src/mesh_flood_duplicate_filter_unit.sv -----
// Top level of the mesh flood duplicate filter
// Accepts one frame header per cycle unless the output stalls, and returns one verdict per
// header. A taken header waits in the st1 register until the result register is free; the
// per-source sequence table is a RAM with registered read, read when the header is taken and
// written back when the verdict moves to the result register. A header from the same source
// as the one just ahead of it takes the written value through a bypass, so equal sources may
// follow each other back to back. The table reads as 255 after reset through one valid bit per
// entry, so no clearing pass is needed and headers are taken from the first cycle after reset.
// While own_address is zero the table is left untouched and every verdict is all zeros.
module mesh_flood_duplicate_filter_unit #(
    parameter int SOURCE_COUNT = mfdf_pkg::SOURCE_COUNT_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // dest_id[7:0], source_id[15:8], sequence_number[23:16], hop_count[31:24]
    input  logic [mfdf_pkg::S_TDATA_W-1:0] s_axis_tdata,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // deliver[0], forward[1], forward_hops[9:2], duplicate[10], zero[15:11]
    output logic [mfdf_pkg::M_TDATA_W-1:0] m_axis_tdata,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [mfdf_pkg::PADDR_W-1:0]   paddr,
    input  logic [mfdf_pkg::PDATA_W-1:0]   pwdata,
    output logic [mfdf_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);

    import mfdf_pkg::*;

    `include "mesh_flood_duplicate_filter_unit_assert.svh"

    localparam int ADDR_W = (SOURCE_COUNT > 1) ? $clog2(SOURCE_COUNT) : 1;
    localparam logic [ID_W:0] SRC_LIMIT = (ID_W + 1)'(SOURCE_COUNT);

    logic [ID_W-1:0]  own_address_reg;
    logic [SEQ_W-1:0] wrap_high_mark_reg;
    logic [SEQ_W-1:0] wrap_low_mark_reg;
    logic             cfg_write;

    header_t           s_hdr;
    logic              s_accept;
    logic [ADDR_W-1:0] s_addr;

    header_t           st1_hdr_reg;
    logic              st1_valid_reg;
    logic              st1_in_table_reg;
    logic              st1_bypass_reg;
    logic [SEQ_W-1:0]  st1_bypass_seq_reg;
    logic [ADDR_W-1:0] st1_addr;
    logic              st1_advance;

    logic [SOURCE_COUNT-1:0] valid_reg;
    logic [SEQ_W-1:0]        ram_rdata;
    logic                    wr_en;

    logic [SEQ_W-1:0] stored;
    logic             is_new;
    logic             configured;
    result_t          res_next;
    result_t          res_reg;
    logic             m_valid_reg;

    // Configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            own_address_reg    <= OWN_ADDRESS_RST;
            wrap_high_mark_reg <= WRAP_HIGH_MARK_RST;
            wrap_low_mark_reg  <= WRAP_LOW_MARK_RST;
        end else if (cfg_write) begin
            case (paddr[3:2])
                REG_OWN_ADDRESS:    own_address_reg    <= pwdata[ID_W-1:0];
                REG_WRAP_HIGH_MARK: wrap_high_mark_reg <= pwdata[SEQ_W-1:0];
                REG_WRAP_LOW_MARK:  wrap_low_mark_reg  <= pwdata[SEQ_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_OWN_ADDRESS:    prdata = PDATA_W'(own_address_reg);
            REG_WRAP_HIGH_MARK: prdata = PDATA_W'(wrap_high_mark_reg);
            REG_WRAP_LOW_MARK:  prdata = PDATA_W'(wrap_low_mark_reg);
            default:            prdata = '0;
        endcase
    end

    // Input side
    assign s_hdr = header_t'({s_axis_tdata[7:0], s_axis_tdata[15:8],
                              s_axis_tdata[23:16], s_axis_tdata[31:24]});
    assign s_addr        = s_hdr.source_id[ADDR_W-1:0];
    assign st1_advance   = st1_valid_reg && (!m_valid_reg || m_axis_tready);
    assign s_axis_tready = !st1_valid_reg || st1_advance;
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign st1_addr      = st1_hdr_reg.source_id[ADDR_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            st1_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            st1_hdr_reg        <= s_hdr;
            st1_in_table_reg   <= {1'b0, s_hdr.source_id} < SRC_LIMIT;
            st1_bypass_reg     <= wr_en && (st1_addr == s_addr);
            st1_bypass_seq_reg <= st1_hdr_reg.sequence_number;
        end
    end

    // Sequence table
    mfdf_ram #(
        .WIDTH (SEQ_W),
        .DEPTH (SOURCE_COUNT)
    ) u_ram (
        .aclk  (aclk),
        .we    (wr_en),
        .waddr (st1_addr),
        .wdata (st1_hdr_reg.sequence_number),
        .re    (s_accept),
        .raddr (s_addr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (wr_en) begin
            valid_reg[st1_addr] <= 1'b1;
        end
    end

    // Verdict
    assign configured = own_address_reg != '0;
    assign wr_en      = st1_advance && configured && st1_in_table_reg;

    always_comb begin
        if (!st1_in_table_reg) begin
            stored = SEQ_RESET;
        end else if (st1_bypass_reg) begin
            stored = st1_bypass_seq_reg;
        end else if (valid_reg[st1_addr]) begin
            stored = ram_rdata;
        end else begin
            stored = SEQ_RESET;
        end
    end

    assign is_new = (st1_hdr_reg.source_id != own_address_reg) &&
                    ((st1_hdr_reg.sequence_number > stored) ||
                     ((stored > wrap_high_mark_reg) &&
                      (st1_hdr_reg.sequence_number < wrap_low_mark_reg)));

    always_comb begin
        res_next = '0;
        if (configured) begin
            res_next.duplicate = !is_new;
            if (is_new) begin
                if (st1_hdr_reg.dest_id == own_address_reg) begin
                    res_next.deliver = 1'b1;
                end else begin
                    res_next.deliver = st1_hdr_reg.dest_id == BROADCAST_ADDR;
                    if (st1_hdr_reg.hop_count > HOP_W'(1)) begin
                        res_next.forward      = 1'b1;
                        res_next.forward_hops = st1_hdr_reg.hop_count - HOP_W'(1);
                    end
                end
            end
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (!m_valid_reg || m_axis_tready) begin
            m_valid_reg <= st1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (st1_advance) begin
            res_reg <= res_next;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = M_TDATA_W'(res_reg);

    `MFDF_ASSERT_NOW(a_stall_blocks_input,
        st1_valid_reg && m_valid_reg && !m_axis_tready, !s_axis_tready,
        "input taken while pipeline stalled")
    `MFDF_ASSERT_NOW(a_deliver_not_dup,
        m_valid_reg && res_reg.deliver, !res_reg.duplicate,
        "duplicate frame delivered")
    `MFDF_ASSERT_NOW(a_forward_hops,
        m_valid_reg && res_reg.forward, !res_reg.duplicate && (res_reg.forward_hops != '0),
        "bad forward verdict")
    `MFDF_ASSERT_NEXT(a_write_sets_valid,
        wr_en, valid_reg[$past(st1_addr)],
        "table write left entry invalid")

endmodule

// ----- dv/testbench.sv -----
// Self-checking testbench for the mesh flood duplicate filter: directed table, then random frames
`timescale 1ns / 100ps

module testbench;
    import mfdf_pkg::*;

    localparam int SRC_COUNT     = SOURCE_COUNT_DEF;
    localparam int SETTLE_CYCLES = 6;
    localparam int STALL_LIMIT   = 4000;
    localparam int LONG_HOLD     = 400;

    typedef enum logic {ROW_FRAME, ROW_CFG} row_kind_t;
    typedef enum logic [1:0] {RX_ALWAYS, RX_RANDOM, RX_PATTERN} rx_mode_t;

    typedef struct {
        row_kind_t  kind;
        logic [1:0] reg_idx;
        logic [7:0] reg_val;
        header_t    hdr;
        bit         typed;
        result_t    verdict;
    } stim_row_t;

    logic                 aclk          = 1'b0;
    logic                 aresetn       = 1'b0;
    logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic                 psel          = 1'b0;
    logic                 penable       = 1'b0;
    logic                 pwrite        = 1'b0;
    logic [PADDR_W-1:0]   paddr         = '0;
    logic [PDATA_W-1:0]   pwdata        = '0;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;

    logic [SEQ_W-1:0] seq_table [SRC_COUNT];
    logic [ID_W-1:0]  cur_own  = OWN_ADDRESS_RST;
    logic [SEQ_W-1:0] cur_high = WRAP_HIGH_MARK_RST;
    logic [SEQ_W-1:0] cur_low  = WRAP_LOW_MARK_RST;

    result_t   verdict_q [$];
    stim_row_t dir_tab [$];
    int        errors        = 0;
    int        burst_left    = 0;
    int        gap_max       = 0;
    int        hold_requests = 0;
    rx_mode_t  rx_mode       = RX_ALWAYS;

    mesh_flood_duplicate_filter_unit #(.SOURCE_COUNT(SRC_COUNT)) uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    function automatic result_t judge_frame(input header_t h);
        result_t          r;
        logic [SEQ_W-1:0] stored;
        logic             fresh;
        bit               tracked;
        r = '0;
        if (cur_own == '0) return r;
        tracked = int'(h.source_id) < SRC_COUNT;
        stored  = tracked ? seq_table[h.source_id] : SEQ_RESET;
        fresh   = (h.source_id != cur_own) &&
                  ((h.sequence_number > stored) ||
                   ((stored > cur_high) && (h.sequence_number < cur_low)));
        if (fresh) begin
            if (h.dest_id == cur_own) begin
                r.deliver = 1'b1;
            end else begin
                if (h.dest_id == BROADCAST_ADDR) r.deliver = 1'b1;
                if (h.hop_count > 8'd1) begin
                    r.forward      = 1'b1;
                    r.forward_hops = h.hop_count - 8'd1;
                end
            end
        end
        if (tracked) seq_table[h.source_id] = h.sequence_number;
        r.duplicate = !fresh;
        return r;
    endfunction

    function automatic header_t make_header(input logic [7:0] own, input logic [7:0] base);
        header_t    h;
        int         pick;
        logic [7:0] stored;
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
            h = header_t'($urandom);
            return h;
        end
        h.source_id = (pick < 14) ? own : base + 8'($urandom_range(0, 7));
        stored = seq_table[h.source_id];
        pick = $urandom_range(0, 99);
        if (pick < 55)      h.sequence_number = stored + 8'($urandom_range(1, 3));
        else if (pick < 72) h.sequence_number = stored - 8'($urandom_range(0, 3));
        else if (pick < 85) h.sequence_number = 8'($urandom_range(0, 60));
        else                h.sequence_number = 8'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 30)      h.dest_id = own;
        else if (pick < 55) h.dest_id = BROADCAST_ADDR;
        else                h.dest_id = 8'($urandom);
        h.hop_count = ($urandom_range(0, 99) < 25) ? 8'($urandom_range(0, 2)) : 8'($urandom);
        return h;
    endfunction

    function automatic stim_row_t frame_row(input logic [7:0] d, s, q, hp);
        stim_row_t r;
        r.kind    = ROW_FRAME;
        r.reg_idx = REG_OWN_ADDRESS;
        r.reg_val = '0;
        r.hdr     = '{dest_id: d, source_id: s, sequence_number: q, hop_count: hp};
        r.typed   = 1'b0;
        r.verdict = '0;
        return r;
    endfunction

    function automatic stim_row_t frame_chk(input logic [7:0] d, s, q, hp,
                                            input logic dl, fw, input logic [7:0] fh,
                                            input logic dup);
        stim_row_t r;
        r = frame_row(d, s, q, hp);
        r.typed   = 1'b1;
        r.verdict = '{duplicate: dup, forward_hops: fh, forward: fw, deliver: dl};
        return r;
    endfunction

    function automatic stim_row_t cfg_row(input logic [1:0] idx, input logic [7:0] val);
        stim_row_t r;
        r = frame_row(8'd0, 8'd0, 8'd0, 8'd0);
        r.kind    = ROW_CFG;
        r.reg_idx = idx;
        r.reg_val = val;
        return r;
    endfunction

    task automatic offer_header(input header_t h, input bit typed, input result_t typed_exp);
        int      gap;
        result_t predicted;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_axis_tdata  <= {h.hop_count, h.sequence_number, h.source_id, h.dest_id};
        s_axis_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_axis_tready);
        predicted = judge_frame(h);
        verdict_q.push_back(typed ? typed_exp : predicted);
    endtask

    task automatic settle();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (verdict_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'({idx, 2'b00});
        pwdata  <= {24'($urandom), val};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_OWN_ADDRESS:    cur_own  = val;
            REG_WRAP_HIGH_MARK: cur_high = val;
            REG_WRAP_LOW_MARK:  cur_low  = val;
            default: ;
        endcase
        @(posedge aclk);
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        errors++;
        if (errors <= 40) $display("tb: mismatch on %s: got %0d, want %0d", what, got, want);
    endtask

    always @(posedge aclk) begin : verdict_check
        result_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (verdict_q.size() == 0) begin
                report_mismatch("unexpected transfer", int'(m_axis_tdata), 0);
            end else begin
                want = verdict_q.pop_front();
                if (m_axis_tdata[0] !== want.deliver)
                    report_mismatch("deliver", int'(m_axis_tdata[0]), int'(want.deliver));
                if (m_axis_tdata[1] !== want.forward)
                    report_mismatch("forward", int'(m_axis_tdata[1]), int'(want.forward));
                if (m_axis_tdata[9:2] !== want.forward_hops)
                    report_mismatch("forward_hops", int'(m_axis_tdata[9:2]),
                                    int'(want.forward_hops));
                if (m_axis_tdata[10] !== want.duplicate)
                    report_mismatch("duplicate", int'(m_axis_tdata[10]), int'(want.duplicate));
            end
        end
    end

    initial begin : rx_pattern
        int hold_left;
        int served;
        int tick;
        hold_left = 0;
        served    = 0;
        tick      = 0;
        forever begin
            @(posedge aclk);
            tick++;
            if (served != hold_requests) begin
                served    = hold_requests;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                case (rx_mode)
                    RX_ALWAYS: m_axis_tready <= 1'b1;
                    RX_RANDOM: m_axis_tready <= ($urandom_range(0, 99) < 60);
                    default:   m_axis_tready <= ((tick % 11) < 7);
                endcase
            end
        end
    end

    always @(posedge aclk) begin : watchdog
        int idle;
        if (!aresetn || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle = 0;
        end else begin
            idle++;
            if (idle >= STALL_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    initial begin : stimulus
        header_t    h;
        stim_row_t  row;
        logic [7:0] own, hi, lo, base;
        int         items;
        for (int i = 0; i < SRC_COUNT; i++) seq_table[i] = SEQ_RESET;

        dir_tab.push_back(frame_chk(8'd5, 8'd1, 8'd10, 8'd3, 0, 0, 8'd0, 0));
        dir_tab.push_back(frame_chk(8'd255, 8'd255, 8'd255, 8'd255, 0, 0, 8'd0, 0));
        dir_tab.push_back(frame_chk(8'd0, 8'd0, 8'd0, 8'd0, 0, 0, 8'd0, 0));
        dir_tab.push_back(cfg_row(REG_OWN_ADDRESS, 8'd5));
        dir_tab.push_back(frame_chk(8'd5, 8'd1, 8'd0, 8'd3, 1, 0, 8'd0, 0));
        dir_tab.push_back(frame_chk(8'd5, 8'd1, 8'd0, 8'd3, 0, 0, 8'd0, 1));
        dir_tab.push_back(frame_chk(8'd9, 8'd1, 8'd1, 8'd3, 0, 1, 8'd2, 0));
        dir_tab.push_back(frame_chk(8'd9, 8'd2, 8'd255, 8'd3, 0, 0, 8'd0, 1));
        dir_tab.push_back(frame_chk(8'd9, 8'd5, 8'd100, 8'd3, 0, 0, 8'd0, 1));
        dir_tab.push_back(frame_chk(8'd5, 8'd5, 8'd101, 8'd3, 0, 0, 8'd0, 1));
        dir_tab.push_back(frame_chk(8'd255, 8'd3, 8'd7, 8'd1, 1, 0, 8'd0, 0));
        dir_tab.push_back(frame_chk(8'd255, 8'd4, 8'd8, 8'd0, 1, 0, 8'd0, 0));
        dir_tab.push_back(frame_chk(8'd9, 8'd6, 8'd9, 8'd255, 0, 1, 8'd254, 0));
        dir_tab.push_back(frame_row(8'd9, 8'd1, 8'd200, 8'd2));
        dir_tab.push_back(frame_row(8'd0, 8'd0, 8'd3, 8'd2));
        dir_tab.push_back(cfg_row(REG_OWN_ADDRESS, 8'd255));
        dir_tab.push_back(frame_chk(8'd255, 8'd10, 8'd20, 8'd5, 1, 0, 8'd0, 0));
        dir_tab.push_back(frame_chk(8'd7, 8'd255, 8'd30, 8'd5, 0, 0, 8'd0, 1));
        dir_tab.push_back(cfg_row(REG_WRAP_HIGH_MARK, 8'd0));
        dir_tab.push_back(cfg_row(REG_WRAP_LOW_MARK, 8'd255));
        dir_tab.push_back(frame_row(8'd7, 8'd1, 8'd100, 8'd9));
        dir_tab.push_back(frame_row(8'd7, 8'd1, 8'd100, 8'd9));
        dir_tab.push_back(cfg_row(REG_WRAP_HIGH_MARK, 8'd255));
        dir_tab.push_back(cfg_row(REG_WRAP_LOW_MARK, 8'd0));
        dir_tab.push_back(frame_row(8'd7, 8'd1, 8'd50, 8'd9));
        dir_tab.push_back(frame_row(8'd7, 8'd1, 8'd255, 8'd9));
        dir_tab.push_back(cfg_row(REG_OWN_ADDRESS, 8'd0));
        dir_tab.push_back(frame_chk(8'd255, 8'd1, 8'd0, 8'd9, 0, 0, 8'd0, 0));

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        gap_max = 2;
        rx_mode = RX_RANDOM;
        foreach (dir_tab[i]) begin
            row = dir_tab[i];
            if (row.kind == ROW_CFG) begin
                settle();
                write_reg(row.reg_idx, row.reg_val);
            end else begin
                offer_header(row.hdr, row.typed, row.verdict);
            end
        end

        for (int p = 0; p < 7; p++) begin
            case (p)
                0: begin
                    own = 8'($urandom_range(1, 254)); hi = 8'd200; lo = 8'd50;
                    gap_max = 0; rx_mode = RX_ALWAYS; items = 160;
                end
                1: begin
                    hi = 8'd200; lo = 8'd50;
                    gap_max = 6; rx_mode = RX_RANDOM; items = 170;
                end
                2: begin
                    own = 8'd255; hi = 8'd200; lo = 8'd50;
                    gap_max = 3; rx_mode = RX_PATTERN; items = 160;
                end
                3: begin
                    own = 8'd1; hi = 8'd0; lo = 8'd255;
                    gap_max = 4; rx_mode = RX_RANDOM; items = 160;
                end
                4: begin
                    own = 8'd254; hi = 8'd255; lo = 8'd0;
                    gap_max = 0; rx_mode = RX_PATTERN; items = 170;
                end
                5: begin
                    own = 8'd0; hi = 8'($urandom); lo = 8'($urandom);
                    gap_max = 2; rx_mode = RX_RANDOM; items = 60;
                end
                default: begin
                    own = 8'($urandom_range(1, 255)); hi = 8'($urandom); lo = 8'($urandom);
                    gap_max = 5; rx_mode = RX_RANDOM; items = 200;
                end
            endcase
            base = own - 8'($urandom_range(0, 7));
            settle();
            write_reg(REG_OWN_ADDRESS, own);
            write_reg(REG_WRAP_HIGH_MARK, hi);
            write_reg(REG_WRAP_LOW_MARK, lo);
            if (p == 1 || p == 4) hold_requests++;
            for (int n = 0; n < items; n++) begin
                h = make_header(own, base);
                offer_header(h, 1'b0, '0);
            end
        end

        settle();
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+src
src/mfdf_pkg.sv
src/mfdf_ram.sv
src/mesh_flood_duplicate_filter_unit.sv
dv/testbench.sv
